// ===== hdl/lsam_pkg.sv =====
// Package for the low-space admission monitor.
// Holds the event, mode and result codes, the field widths and the limit reset values.
// No dependencies.
package lsam_pkg;

  // Width of a free-space sample and of each limit register
  localparam int unsigned SPACE_W = 31;

  // Limit reset values
  localparam logic [SPACE_W-1:0] LOW_LIMIT_RST  = SPACE_W'(8 * 1024);
  localparam logic [SPACE_W-1:0] HIGH_LIMIT_RST = SPACE_W'(16 * 1024);

  // Configuration register indexes
  localparam logic CFG_LOW_LIMIT  = 1'b0;
  localparam logic CFG_HIGH_LIMIT = 1'b1;

  // Event kind carried with each input item
  typedef enum logic [1:0] {
    OP_ARRIVAL     = 2'd0,
    OP_MON_DONE    = 2'd1,
    OP_RESUME_DONE = 2'd2
  } op_e;

  // Controller mode
  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_LOW    = 2'd1,
    MODE_HIGH   = 2'd2,
    MODE_RESUME = 2'd3
  } mode_e;

  // Watch armed by this event
  typedef enum logic [1:0] {
    ARM_NONE = 2'd0,
    ARM_LOW  = 2'd1,
    ARM_HIGH = 2'd2
  } arm_e;

  // Space notification raised by this event
  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_FULL  = 2'd1,
    EV_AVAIL = 2'd2
  } space_ev_e;

  // Current limit settings
  typedef struct packed {
    logic [SPACE_W-1:0] low_limit;
    logic [SPACE_W-1:0] high_limit;
  } limits_t;

  // One input event
  typedef struct packed {
    op_e                operation;
    logic [SPACE_W-1:0] free_space;
    logic               space_read_error;
    logic               is_priority_class;
    logic               completion_ok;
  } event_t;

  // One decision result
  typedef struct packed {
    logic      unexpected_event;
    mode_e     mode_now;
    space_ev_e space_event;
    logic      resume_request;
    logic      cancel_monitor;
    arm_e      arm_monitor;
    logic      reject;
  } result_t;

endpackage

// ===== hdl/lsam_cfg_regs.sv =====
// Limit registers of the low-space admission monitor.
// Plain write port, no read-back. Depends on lsam_pkg.
module lsam_cfg_regs (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic                    cfg_idx_i,
  input  logic [lsam_pkg::SPACE_W-1:0] cfg_data_i,
  output lsam_pkg::limits_t       limits_o
);
  import lsam_pkg::*;

  logic [SPACE_W-1:0] low_limit_q;
  logic [SPACE_W-1:0] high_limit_q;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_limit_q  <= LOW_LIMIT_RST;
      high_limit_q <= HIGH_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LOW_LIMIT:  low_limit_q  <= cfg_data_i;
        CFG_HIGH_LIMIT: high_limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign limits_o.low_limit  = low_limit_q;
  assign limits_o.high_limit = high_limit_q;

endmodule

// ===== hdl/lsam_decide.sv =====
// Decision logic and controller state of the low-space admission monitor.
// Computes the result of the staged event and commits the state when it moves on.
// Depends on lsam_pkg.
module lsam_decide (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              commit_i,
  input  lsam_pkg::event_t  event_i,
  input  lsam_pkg::limits_t limits_i,
  output lsam_pkg::result_t result_o
);
  import lsam_pkg::*;

  mode_e mode_q, mode_d;
  logic  rej_prio_q, rej_prio_d;
  logic  rej_other_q, rej_other_d;

  logic               above_high;
  logic               above_low;
  logic [SPACE_W-1:0] mon_limit;
  logic               above_mon;

  // Threshold compares; a read error counts as below everything
  assign above_high = !event_i.space_read_error && (event_i.free_space >= limits_i.high_limit);
  assign above_low  = !event_i.space_read_error && (event_i.free_space >= limits_i.low_limit);
  assign mon_limit  = (mode_q == MODE_LOW) ? limits_i.low_limit : limits_i.high_limit;
  assign above_mon  = !event_i.space_read_error && (event_i.free_space >= mon_limit);

  // Next state and result fields
  always_comb begin
    mode_d      = mode_q;
    rej_prio_d  = rej_prio_q;
    rej_other_d = rej_other_q;
    result_o    = '0;

    case (event_i.operation)
      OP_ARRIVAL: begin
        if (!(above_high || (above_low && event_i.is_priority_class))) begin
          result_o.reject = 1'b1;
          if (event_i.is_priority_class) begin
            rej_prio_d = 1'b1;
          end else begin
            rej_other_d = 1'b1;
          end
          if (!above_low) begin
            // low watch arms from idle and replaces a high watch
            if (mode_q == MODE_IDLE || mode_q == MODE_HIGH) begin
              result_o.cancel_monitor = (mode_q == MODE_HIGH);
              mode_d                  = MODE_LOW;
              result_o.arm_monitor    = ARM_LOW;
              result_o.space_event    = EV_FULL;
            end
          end else if (mode_q == MODE_IDLE) begin
            mode_d               = MODE_HIGH;
            result_o.arm_monitor = ARM_HIGH;
            result_o.space_event = EV_FULL;
          end
        end
      end
      OP_MON_DONE: begin
        if (mode_q == MODE_LOW || mode_q == MODE_HIGH) begin
          if (above_mon) begin
            rej_prio_d              = 1'b0;
            rej_other_d             = 1'b0;
            mode_d                  = MODE_RESUME;
            result_o.resume_request = 1'b1;
            result_o.space_event    = EV_AVAIL;
          end else if (event_i.completion_ok) begin
            result_o.arm_monitor = (mode_q == MODE_LOW) ? ARM_LOW : ARM_HIGH;
            result_o.space_event = EV_FULL;
          end else begin
            mode_d = MODE_IDLE;
          end
        end else begin
          result_o.unexpected_event = 1'b1;
        end
      end
      OP_RESUME_DONE: begin
        if (mode_q == MODE_RESUME) begin
          if (rej_prio_q) begin
            mode_d               = MODE_LOW;
            result_o.arm_monitor = ARM_LOW;
            result_o.space_event = EV_FULL;
          end else if (rej_other_q) begin
            mode_d               = MODE_HIGH;
            result_o.arm_monitor = ARM_HIGH;
            result_o.space_event = EV_FULL;
          end else begin
            mode_d = MODE_IDLE;
          end
        end else begin
          result_o.unexpected_event = 1'b1;
        end
      end
      default: ;  // reserved code: no effect
    endcase

    result_o.mode_now = mode_d;
  end

  // State commit when the event enters the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_IDLE;
      rej_prio_q  <= 1'b0;
      rej_other_q <= 1'b0;
    end else if (commit_i) begin
      mode_q      <= mode_d;
      rej_prio_q  <= rej_prio_d;
      rej_other_q <= rej_other_d;
    end
  end

endmodule

// ===== hdl/low_space_admission_monitor_top.sv =====
// Top level of the low-space admission monitor.
// Input register, decision stage and result register. Depends on lsam_pkg,
// lsam_cfg_regs and lsam_decide.

// An event transaction is taken into an input register, decided
// combinationally from there and written into the result register when
// that register is free or being drained. One event is accepted every
// cycle as long as results are taken; the figure is set by the single
// decision stage between the input register and the result register,
// where the controller state is committed as an event moves into the
// result register. Each event yields exactly one result. The user writes
// limits through the configuration port only while no event is in flight;
// the block itself does not enforce this. There is no clearing pass after
// reset.
module low_space_admission_monitor_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration port
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [30:0] cfg_data_i,
  // event stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [30:0] free_space, [31] space_read_error, [32] is_priority_class,
  // [33] completion_ok, [39:34] zero
  input  logic [39:0] s_axis_tdata,
  // [1:0] operation
  input  logic [1:0]  s_axis_tuser,
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] reject, [2:1] arm_monitor, [3] cancel_monitor, [4] resume_request,
  // [6:5] space_event, [8:7] mode_now, [9] unexpected_event, [15:10] zero
  output logic [15:0] m_axis_tdata
);
  import lsam_pkg::*;

  limits_t limits;
  event_t  evt_q;
  logic    evt_valid_q;
  logic    move;
  result_t result;
  result_t res_q;
  logic    res_valid_q;

  lsam_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .limits_o   (limits)
  );

  // Staged event moves on when the result register is free or being drained
  assign move          = evt_valid_q && (!res_valid_q || m_axis_tready);
  assign s_axis_tready = !evt_valid_q || move;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      evt_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      evt_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      evt_q.operation         <= op_e'(s_axis_tuser);
      evt_q.free_space        <= s_axis_tdata[30:0];
      evt_q.space_read_error  <= s_axis_tdata[31];
      evt_q.is_priority_class <= s_axis_tdata[32];
      evt_q.completion_ok     <= s_axis_tdata[33];
    end
  end

  lsam_decide u_decide (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .commit_i (move),
    .event_i  (evt_q),
    .limits_i (limits),
    .result_o (result)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (!res_valid_q || m_axis_tready) begin
      res_valid_q <= evt_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      res_q <= result;
    end
  end

  assign m_axis_tvalid = res_valid_q;
  assign m_axis_tdata  = {6'd0,
                          res_q.unexpected_event,
                          res_q.mode_now,
                          res_q.space_event,
                          res_q.resume_request,
                          res_q.cancel_monitor,
                          res_q.arm_monitor,
                          res_q.reject};

endmodule

// ===== hdl/lsam_checker.sv =====
// Port-level checks for the low-space admission monitor, with the bind that
// attaches them to the top level. Depends on low_space_admission_monitor_top.
module lsam_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);
  logic       out_acc;
  logic [1:0] prev_mode_q;
  logic       have_prev_q;

  assign out_acc = m_axis_tvalid && m_axis_tready;

  // Mode reported by the last delivered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_prev_q <= 1'b0;
      prev_mode_q <= 2'd0;
    end else if (out_acc) begin
      have_prev_q <= 1'b1;
      prev_mode_q <= m_axis_tdata[8:7];
    end
  end

  // No result shows while reset stays asserted
  a_reset_quiet: assert property (@(posedge clk_i)
    (!rst_ni && $past(!rst_ni)) |-> !m_axis_tvalid)
    else $error("result valid during reset");

  // Input stalls only behind a stalled result
  a_ready_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without output backpressure");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

  // An out-of-place completion leaves the mode unchanged
  a_unexpected_keeps_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && have_prev_q && m_axis_tdata[9]) |-> (m_axis_tdata[8:7] == prev_mode_q))
    else $error("unexpected completion changed mode");

  // A cancel only replaces a high watch
  a_cancel_from_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && have_prev_q && m_axis_tdata[3]) |-> (prev_mode_q == 2'd2))
    else $error("cancel without a high watch");

endmodule

bind low_space_admission_monitor_top lsam_checker u_lsam_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== bench/lsam_decision_checker.sv =====
// Checker for the low-space admission monitor: predicts each decision and compares it.
// Watches the configuration port and both streams of the block. Depends on lsam_pkg.
`timescale 1ns / 100ps

module lsam_decision_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [lsam_pkg::SPACE_W-1:0] cfg_data_i,
  input  logic                         s_tvalid_i,
  input  logic                         s_tready_i,
  // [30:0] free_space, [31] space_read_error, [32] is_priority_class,
  // [33] completion_ok, [39:34] zero
  input  logic [39:0]                  s_tdata_i,
  // [1:0] operation
  input  logic [1:0]                   s_tuser_i,
  input  logic                         m_tvalid_i,
  input  logic                         m_tready_i,
  // [0] reject, [2:1] arm_monitor, [3] cancel_monitor, [4] resume_request,
  // [6:5] space_event, [8:7] mode_now, [9] unexpected_event, [15:10] zero
  input  logic [15:0]                  m_tdata_i,
  output int unsigned                  fail_count_o,
  output int unsigned                  pending_o
);
  import lsam_pkg::*;

  // Shadow of the controller state and limits
  limits_t limits_q;
  mode_e   mode_q;
  logic    prio_flag_q;
  logic    other_flag_q;

  // Decisions still owed by the block, oldest first
  result_t pending_decisions[$];

  function automatic logic space_fits(logic [SPACE_W-1:0] sample, logic err,
                                      logic [SPACE_W-1:0] limit);
    return !err && (sample >= limit);
  endfunction

  // Decide one event and advance the shadow state
  function automatic result_t next_decision(event_t ev);
    result_t            res;
    logic               fits_high;
    logic               fits_low;
    logic [SPACE_W-1:0] watch_limit;
    res = '0;
    case (ev.operation)
      OP_ARRIVAL: begin
        fits_high = space_fits(ev.free_space, ev.space_read_error, limits_q.high_limit);
        fits_low  = space_fits(ev.free_space, ev.space_read_error, limits_q.low_limit);
        if (!(fits_high || (fits_low && ev.is_priority_class))) begin
          res.reject = 1'b1;
          if (ev.is_priority_class) prio_flag_q = 1'b1;
          else other_flag_q = 1'b1;
          if (!fits_low) begin
            // low watch is armed from idle and replaces a high watch
            if (mode_q == MODE_IDLE || mode_q == MODE_HIGH) begin
              res.cancel_monitor = (mode_q == MODE_HIGH);
              mode_q = MODE_LOW;
              res.arm_monitor = ARM_LOW;
              res.space_event = EV_FULL;
            end
          end else if (mode_q == MODE_IDLE) begin
            mode_q = MODE_HIGH;
            res.arm_monitor = ARM_HIGH;
            res.space_event = EV_FULL;
          end
        end
      end
      OP_MON_DONE: begin
        if (mode_q == MODE_LOW || mode_q == MODE_HIGH) begin
          watch_limit = (mode_q == MODE_LOW) ? limits_q.low_limit : limits_q.high_limit;
          if (space_fits(ev.free_space, ev.space_read_error, watch_limit)) begin
            prio_flag_q = 1'b0;
            other_flag_q = 1'b0;
            mode_q = MODE_RESUME;
            res.resume_request = 1'b1;
            res.space_event = EV_AVAIL;
          end else if (ev.completion_ok) begin
            res.arm_monitor = (mode_q == MODE_LOW) ? ARM_LOW : ARM_HIGH;
            res.space_event = EV_FULL;
          end else begin
            mode_q = MODE_IDLE;
          end
        end else begin
          res.unexpected_event = 1'b1;
        end
      end
      OP_RESUME_DONE: begin
        if (mode_q == MODE_RESUME) begin
          if (prio_flag_q) begin
            mode_q = MODE_LOW;
            res.arm_monitor = ARM_LOW;
            res.space_event = EV_FULL;
          end else if (other_flag_q) begin
            mode_q = MODE_HIGH;
            res.arm_monitor = ARM_HIGH;
            res.space_event = EV_FULL;
          end else begin
            mode_q = MODE_IDLE;
          end
        end else begin
          res.unexpected_event = 1'b1;
        end
      end
      default: ;  // reserved code leaves the state alone
    endcase
    res.mode_now = mode_q;
    return res;
  endfunction

  task automatic check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
      fail_count_o++;
    end
  endtask

  // Predict on event acceptance, compare on result acceptance
  always @(posedge clk_i or negedge rst_ni) begin
    event_t  ev;
    result_t want;
    result_t got;
    if (!rst_ni) begin
      limits_q.low_limit  = LOW_LIMIT_RST;
      limits_q.high_limit = HIGH_LIMIT_RST;
      mode_q = MODE_IDLE;
      prio_flag_q = 1'b0;
      other_flag_q = 1'b0;
      pending_decisions.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (s_tvalid_i && s_tready_i) begin
        ev.operation         = op_e'(s_tuser_i);
        ev.free_space        = s_tdata_i[SPACE_W-1:0];
        ev.space_read_error  = s_tdata_i[31];
        ev.is_priority_class = s_tdata_i[32];
        ev.completion_ok     = s_tdata_i[33];
        pending_decisions.push_back(next_decision(ev));
      end
      if (m_tvalid_i && m_tready_i) begin
        got = result_t'(m_tdata_i[9:0]);
        if (pending_decisions.size() == 0) begin
          $display("%0t: result with nothing pending, expected none actual %h",
                   $time, m_tdata_i);
          fail_count_o++;
        end else begin
          want = pending_decisions.pop_front();
          check_field("reject", want.reject, got.reject);
          check_field("arm_monitor", want.arm_monitor, got.arm_monitor);
          check_field("cancel_monitor", want.cancel_monitor, got.cancel_monitor);
          check_field("resume_request", want.resume_request, got.resume_request);
          check_field("space_event", want.space_event, got.space_event);
          check_field("mode_now", want.mode_now, got.mode_now);
          check_field("unexpected_event", want.unexpected_event, got.unexpected_event);
          check_field("padding", 0, m_tdata_i[15:10]);
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_LOW_LIMIT) limits_q.low_limit = cfg_data_i;
        else limits_q.high_limit = cfg_data_i;
      end
      pending_o = pending_decisions.size();
    end
  end

endmodule

// ===== bench/low_space_admission_monitor_top_test.sv =====
// Testbench top for the low-space admission monitor: clock, reset, stimulus and verdict.
// Depends on lsam_pkg, low_space_admission_monitor_top and lsam_decision_checker.
`timescale 1ns / 100ps

module low_space_admission_monitor_top_test;
  import lsam_pkg::*;

  localparam logic [1:0]         OP_RESERVED  = 2'd3;
  localparam logic [SPACE_W-1:0] SPACE_MAX    = '1;
  localparam int unsigned        STALL_LIMIT  = 3000;
  localparam int unsigned        DRAIN_CYCLES = 4;
  localparam int unsigned        PHASE_ITEMS  = 250;

  logic               clk_i;
  logic               rst_ni        = 1'b0;
  logic               cfg_we_i      = 1'b0;
  logic               cfg_idx_i     = CFG_LOW_LIMIT;
  logic [SPACE_W-1:0] cfg_data_i    = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [39:0]        s_axis_tdata  = '0;  // [30:0] space, [31] err, [32] prio, [33] ok
  logic [1:0]         s_axis_tuser  = '0;  // [1:0] operation
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [15:0]        m_axis_tdata;        // packed result fields, reject lowest

  int unsigned        fail_count;
  int unsigned        pending_count;
  int unsigned        quiet_cycles  = 0;
  int unsigned        send_idle_pct = 0;
  int unsigned        recv_stall_pct = 0;
  logic [SPACE_W-1:0] low_set       = LOW_LIMIT_RST;
  logic [SPACE_W-1:0] high_set      = HIGH_LIMIT_RST;

  low_space_admission_monitor_top i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  lsam_decision_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_i  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .s_tuser_i   (s_axis_tuser),
    .m_tvalid_i  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_i   (m_axis_tdata),
    .fail_count_o(fail_count),
    .pending_o   (pending_count)
  );

  // 8 ns clock
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Result side backpressure
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog on cycles without any accepted transaction
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Offer one event and hold it until accepted
  task automatic send_event(logic [1:0] op, logic [SPACE_W-1:0] space, logic err,
                            logic prio, logic ok);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {6'b0, ok, prio, err, space};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Stop sending until every decision has come back
  task automatic drain_decisions();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending_count != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic program_limits(logic [SPACE_W-1:0] lo, logic [SPACE_W-1:0] hi);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_LOW_LIMIT;
    cfg_data_i <= lo;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_HIGH_LIMIT;
    cfg_data_i <= hi;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    low_set  = lo;
    high_set = hi;
  endtask

  // Samples cluster around the limits, with extremes and full-range noise
  function automatic logic [SPACE_W-1:0] pick_space();
    case ($urandom_range(7))
      0: return '0;
      1: return SPACE_MAX;
      2: return low_set;
      3: return low_set - 1'b1;
      4: return high_set;
      5: return high_set - 1'b1;
      6: return low_set + SPACE_W'($urandom_range(64));
      default: return SPACE_W'($urandom);
    endcase
  endfunction

  task automatic random_event();
    int unsigned pick;
    logic [1:0]  op;
    pick = $urandom_range(99);
    if (pick < 45) op = OP_ARRIVAL;
    else if (pick < 75) op = OP_MON_DONE;
    else if (pick < 95) op = OP_RESUME_DONE;
    else op = OP_RESERVED;
    send_event(op, pick_space(), ($urandom_range(7) == 0), 1'($urandom_range(1)),
               ($urandom_range(3) != 0));
  endtask

  initial begin
    logic [SPACE_W-1:0] lo;
    logic [SPACE_W-1:0] hi;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed walk through the modes at the reset limits
    send_event(OP_MON_DONE, SPACE_MAX, 1'b0, 1'b0, 1'b1);          // completion while idle
    send_event(OP_RESUME_DONE, SPACE_MAX, 1'b0, 1'b0, 1'b1);       // resume while idle
    send_event(OP_RESERVED, SPACE_MAX, 1'b1, 1'b1, 1'b1);          // reserved code
    send_event(OP_ARRIVAL, SPACE_MAX, 1'b0, 1'b0, 1'b0);           // plenty of space
    send_event(OP_ARRIVAL, LOW_LIMIT_RST, 1'b0, 1'b1, 1'b0);       // priority at low limit
    send_event(OP_ARRIVAL, LOW_LIMIT_RST, 1'b0, 1'b0, 1'b0);       // arms high watch
    send_event(OP_ARRIVAL, LOW_LIMIT_RST - 1'b1, 1'b0, 1'b1, 1'b0);   // low replaces high
    send_event(OP_ARRIVAL, SPACE_MAX, 1'b1, 1'b1, 1'b0);           // read error, watching
    send_event(OP_MON_DONE, LOW_LIMIT_RST - 1'b1, 1'b0, 1'b0, 1'b1);  // still low, re-arm
    send_event(OP_MON_DONE, SPACE_MAX, 1'b1, 1'b0, 1'b1);          // read error, re-arm
    send_event(OP_MON_DONE, LOW_LIMIT_RST, 1'b0, 1'b0, 1'b0);      // space back, resume
    send_event(OP_MON_DONE, SPACE_MAX, 1'b0, 1'b0, 1'b1);          // completion in resume
    send_event(OP_ARRIVAL, '0, 1'b0, 1'b0, 1'b0);                  // arrival in resume
    send_event(OP_RESUME_DONE, '0, 1'b0, 1'b0, 1'b0);              // re-arm high from flag
    send_event(OP_MON_DONE, HIGH_LIMIT_RST - 1'b1, 1'b0, 1'b0, 1'b0); // failed watch, idle
    send_event(OP_ARRIVAL, HIGH_LIMIT_RST, 1'b0, 1'b0, 1'b0);      // at high limit
    send_event(OP_ARRIVAL, SPACE_MAX, 1'b1, 1'b0, 1'b1);           // read error from idle
    send_event(OP_MON_DONE, SPACE_MAX, 1'b0, 1'b1, 1'b0);          // resume
    send_event(OP_ARRIVAL, '0, 1'b0, 1'b1, 1'b1);                  // priority in resume
    send_event(OP_RESUME_DONE, SPACE_MAX, 1'b0, 1'b0, 1'b0);       // re-arm low from flag
    send_event(OP_MON_DONE, SPACE_MAX, 1'b0, 1'b0, 1'b0);          // resume, flags cleared
    send_event(OP_RESUME_DONE, '0, 1'b1, 1'b1, 1'b1);              // no flags, idle
    send_event(OP_ARRIVAL, HIGH_LIMIT_RST - 1'b1, 1'b0, 1'b1, 1'b0);  // priority accepted
    send_event(OP_RESERVED, '0, 1'b0, 1'b0, 1'b0);

    // Random phases, each with its own limits; the idling pattern follows the phase modulo four
    for (int phase = 0; phase < 5; phase++) begin
      drain_decisions();
      case (phase)
        0: begin lo = LOW_LIMIT_RST; hi = HIGH_LIMIT_RST; end
        1: begin lo = '0; hi = '0; end
        2: begin lo = SPACE_MAX; hi = SPACE_MAX; end
        3: begin
          lo = SPACE_W'($urandom_range(32'h0010_0000, 4096));
          hi = SPACE_W'($urandom_range(lo - 1, 0));
        end
        default: begin lo = SPACE_W'($urandom); hi = SPACE_W'($urandom); end
      endcase
      program_limits(lo, hi);
      case (phase % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 80; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 80; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        random_event();
        if (n % 90 == 89) drain_decisions();
      end
    end

    drain_decisions();
    @(negedge clk_i);
    if (fail_count == 0 && pending_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
